// ===== design/lzwcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwcd_pkg
// Shared constants, types and codes for the LZSS window copy decoder.
// ----------------------------------------------------------------------------
package lzwcd_pkg;

  // Window geometry and run limits
  localparam int WINDOW_SIZE    = 4096;
  localparam int WIN_AW         = $clog2(WINDOW_SIZE);
  localparam int MIN_MATCH_BIAS = 2;
  localparam int MAX_RUN        = 60;
  localparam int RUN_W          = $clog2(MAX_RUN + 1);

  // Field widths
  localparam int SYM_W  = 9;
  localparam int DIST_W = 12;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 24;

  // Symbol coding
  localparam int LITERAL_LIMIT = 256;
  localparam int SYMBOL_BASE   = 255;
  localparam int LEN_CALC_W    = SYM_W + 1;

  // Window reset contents and first write position
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam int WP_RESET = (WINDOW_SIZE - MAX_RUN) % WINDOW_SIZE;

  // Queue depths
  localparam int TQ_DEPTH = 2;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // Classified token between front and back end
  typedef struct packed {
    logic              is_lit;
    logic [BYTE_W-1:0] lit_byte;
    logic [RUN_W-1:0]  run_len;
    logic [WIN_AW-1:0] dist_off;
  } tok_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              block_done;
  } out_item_t;

endpackage

// ===== design/lzwcd_ifs.sv =====
// ----------------------------------------------------------------------------
// lzwcd_ifs
// Valid/ready channel interfaces for tokens in and bytes out.
// ----------------------------------------------------------------------------
interface lzwcd_tok_if;
  logic                         valid;
  logic                         ready;
  logic [lzwcd_pkg::SYM_W-1:0]  symbol;
  logic [lzwcd_pkg::DIST_W-1:0] distance;

  modport source (output valid, output symbol, output distance, input ready);
  modport sink   (input valid, input symbol, input distance, output ready);
endinterface

interface lzwcd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [lzwcd_pkg::BYTE_W-1:0] out_byte;
  logic                         run_last;
  logic                         block_done;

  modport source (output valid, output out_byte, output run_last, output block_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input block_done,
                  output ready);
endinterface

// ===== design/lzwcd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lzwcd_front.sv =====
// ----------------------------------------------------------------------------
// lzwcd_front
// Accepts tokens, splits literals from back-references, sizes the run.
// ----------------------------------------------------------------------------
module lzwcd_front (
  lzwcd_tok_if.sink        in_tok,
  input  logic             tq_full,
  output logic             tq_push,
  output lzwcd_pkg::tok_t  tq_tok
);

  localparam int LW = lzwcd_pkg::LEN_CALC_W;
  localparam int RW = lzwcd_pkg::RUN_W;
  localparam int AW = lzwcd_pkg::WIN_AW;

  logic [LW-1:0] len_full;

  // Take an item whenever the token queue has room
  assign in_tok.ready = !tq_full;
  assign tq_push      = in_tok.valid && !tq_full;

  // Run length from symbol, saturated to the longest run
  assign len_full = {1'b0, in_tok.symbol}
                  - LW'(lzwcd_pkg::SYMBOL_BASE - lzwcd_pkg::MIN_MATCH_BIAS);

  always_comb begin
    tq_tok.is_lit   = in_tok.symbol < lzwcd_pkg::SYM_W'(lzwcd_pkg::LITERAL_LIMIT);
    tq_tok.lit_byte = in_tok.symbol[lzwcd_pkg::BYTE_W-1:0];
    tq_tok.run_len  = (len_full > LW'(lzwcd_pkg::MAX_RUN)) ? RW'(lzwcd_pkg::MAX_RUN)
                                                           : RW'(len_full);
    tq_tok.dist_off = AW'(in_tok.distance);
  end

endmodule

// ===== design/lzwcd_tok_fifo.sv =====
// ----------------------------------------------------------------------------
// lzwcd_tok_fifo
// Short queue of classified tokens between the front and back end.
// ----------------------------------------------------------------------------
module lzwcd_tok_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lzwcd_pkg::tok_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lzwcd_pkg::tok_t head_tok
);

  localparam int AW    = lzwcd_pkg::TQ_AW;
  localparam int DEPTH = lzwcd_pkg::TQ_DEPTH;

  lzwcd_pkg::tok_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     cnt_r;
  logic            do_push, do_pop;

  assign full      = cnt_r == (AW+1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_tok  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== design/lzwcd_back.sv =====
// ----------------------------------------------------------------------------
// lzwcd_back
// Runs tokens against the ring window: one byte issued per cycle while the output queue has room,
// window read registered, byte written back and queued for output in the cycle after issue.
// ----------------------------------------------------------------------------
module lzwcd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lzwcd_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                         tq_valid,
  input  lzwcd_pkg::tok_t              tq_tok,
  output logic                         tq_pop,
  lzwcd_byte_if.source                 out_bytes
);

  localparam int AW  = lzwcd_pkg::WIN_AW;
  localparam int RW  = lzwcd_pkg::RUN_W;
  localparam int CW  = lzwcd_pkg::CNT_W;
  localparam int BW  = lzwcd_pkg::BYTE_W;
  localparam int QAW = lzwcd_pkg::OQ_AW;
  localparam int QD  = lzwcd_pkg::OQ_DEPTH;

  // Issue-side state
  logic          act_r, act_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic          dist0_r, dist0_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lim_r;
  logic [AW:0]   fill_r;

  // Read stage
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_lit_r, s1_fwd_r, s1_blank_r, s1_last_r, s1_done_r;
  logic [BW-1:0] s1_lbyte_r;
  logic [AW-1:0] s1_wp_r;
  logic [BW-1:0] prev_r;

  // Output queue
  lzwcd_pkg::out_item_t oq_mem_r [QD];
  logic [QAW-1:0] oq_wr_r, oq_rd_r;
  logic [QAW:0]   oq_cnt_r, oq_occ;
  logic           oq_pop;

  logic          limit_hit, issue_ok, issue, issue_lit, issue_fwd, issue_blank;
  logic          issue_last, issue_done;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] blank_off;
  logic [BW-1:0] ram_rdata, s2_byte;

  // Window memory
  lzwcd_ram #(
    .WIDTH (BW),
    .DEPTH (lzwcd_pkg::WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_wp_r),
    .wdata (s2_byte),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  // Room check: the queue must take every byte in flight
  assign oq_pop   = out_bytes.valid && out_bytes.ready;
  assign oq_occ   = oq_cnt_r - {{QAW{1'b0}}, oq_pop} + {{QAW{1'b0}}, s1_valid_r};
  assign issue_ok = oq_occ < (QAW+1)'(QD);

  assign limit_hit = cnt_r >= lim_r;
  assign cnt_inc   = cnt_r + CW'(1);

  // Entries past the fill count have never been written and read as space
  assign blank_off = src_r - AW'(lzwcd_pkg::WP_RESET);

  // Issue control
  always_comb begin
    act_nxt     = act_r;
    rem_nxt     = rem_r;
    src_nxt     = src_r;
    dist0_nxt   = dist0_r;
    wp_nxt      = wp_r;
    cnt_nxt     = cnt_r;
    tq_pop      = 1'b0;
    issue       = 1'b0;
    issue_lit   = 1'b0;
    issue_fwd   = 1'b0;
    issue_blank = 1'b0;
    issue_done  = cnt_inc == lim_r;
    issue_last  = 1'b0;

    if (!act_r) begin
      if (tq_valid) begin
        if (limit_hit) begin
          // Drop tokens once the block is complete
          tq_pop = 1'b1;
        end else if (tq_tok.is_lit) begin
          if (issue_ok) begin
            tq_pop     = 1'b1;
            issue      = 1'b1;
            issue_lit  = 1'b1;
            issue_last = 1'b1;
          end
        end else begin
          // Load a run
          tq_pop    = 1'b1;
          act_nxt   = 1'b1;
          rem_nxt   = tq_tok.run_len;
          src_nxt   = wp_r - tq_tok.dist_off - AW'(1);
          dist0_nxt = tq_tok.dist_off == '0;
        end
      end
    end else if (limit_hit) begin
      act_nxt = 1'b0;
    end else if (issue_ok) begin
      // Copy one byte of the run
      issue       = 1'b1;
      issue_fwd   = dist0_r && s1_valid_r;
      issue_blank = !fill_r[AW] && ({1'b0, blank_off} >= fill_r);
      issue_last  = (rem_r == RW'(1)) || issue_done;
      rem_nxt     = rem_r - RW'(1);
      src_nxt     = src_r + AW'(1);
      if (issue_last) begin
        act_nxt = 1'b0;
      end
    end

    if (issue) begin
      wp_nxt  = wp_r + AW'(1);
      cnt_nxt = cnt_inc;
    end
    s1_valid_nxt = issue;
  end

  // Issue-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      rem_r      <= '0;
      src_r      <= '0;
      dist0_r    <= 1'b0;
      wp_r       <= AW'(lzwcd_pkg::WP_RESET);
      cnt_r      <= '0;
      lim_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      act_r      <= act_nxt;
      rem_r      <= rem_nxt;
      src_r      <= src_nxt;
      dist0_r    <= dist0_nxt;
      wp_r       <= wp_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Hold byte attributes alongside the window read
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_lit_r   <= issue_lit;
      s1_lbyte_r <= tq_tok.lit_byte;
      s1_fwd_r   <= issue_fwd;
      s1_blank_r <= issue_blank;
      s1_last_r  <= issue_last;
      s1_done_r  <= issue_done;
      s1_wp_r    <= wp_r;
    end
  end

  // Select the byte: literal, forwarded, unwritten, or window data
  always_comb begin
    if (s1_lit_r) begin
      s2_byte = s1_lbyte_r;
    end else if (s1_fwd_r) begin
      s2_byte = prev_r;
    end else if (s1_blank_r) begin
      s2_byte = lzwcd_pkg::SPACE_BYTE;
    end else begin
      s2_byte = ram_rdata;
    end
  end

  // Track the last byte and how much of the window holds real data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (s1_valid_r && !fill_r[AW]) begin
      fill_r <= fill_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      prev_r <= s2_byte;
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      oq_mem_r[oq_wr_r] <= '{out_byte: s2_byte, run_last: s1_last_r,
                             block_done: s1_done_r};
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_valid_r) begin
        oq_wr_r <= oq_wr_r + QAW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + QAW'(1);
      end
      oq_cnt_r <= oq_occ;
    end
  end

  assign out_bytes.valid      = oq_cnt_r != '0;
  assign out_bytes.out_byte   = oq_mem_r[oq_rd_r].out_byte;
  assign out_bytes.run_last   = oq_mem_r[oq_rd_r].run_last;
  assign out_bytes.block_done = oq_mem_r[oq_rd_r].block_done;

endmodule

// ===== design/lzwcd_front_q.sv =====
// ----------------------------------------------------------------------------
// lzwcd_front_q
// Front end with its token queue: classifies items and buffers them so the
// input side keeps moving while the back end copies a run.
// ----------------------------------------------------------------------------
module lzwcd_front_q (
  input  logic            clk,
  input  logic            rst_n,
  lzwcd_tok_if.sink       in_tok,
  input  logic            tq_pop,
  output logic            tq_valid,
  output lzwcd_pkg::tok_t tq_tok
);

  logic            tq_full, tq_push;
  lzwcd_pkg::tok_t push_tok;

  // Classify
  lzwcd_front u_front (
    .in_tok  (in_tok),
    .tq_full (tq_full),
    .tq_push (tq_push),
    .tq_tok  (push_tok)
  );

  // Buffer
  lzwcd_tok_fifo u_tq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tq_push),
    .push_tok  (push_tok),
    .full      (tq_full),
    .pop       (tq_pop),
    .not_empty (tq_valid),
    .head_tok  (tq_tok)
  );

endmodule

// ===== design/lzss_window_copy_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_window_copy_decoder
// LZSS back end: expands literal and back-reference tokens through a
// 4096-byte ring window into a byte stream, cut at a programmable limit.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  in_tok     in   valid/ready      symbol[8:0], distance[11:0]
//  out_bytes  out  valid/ready      out_byte[7:0], run_last, block_done
//  cfg        in   cfg_we           cfg_wdata[23:0] (output limit)
//
//  A literal is issued directly; a run is first loaded and then copied byte
//  by byte through the single window read port.
//  Reset is immediate: no clearing pass; window entries not yet written
//  since reset read as space, tracked by a fill count.
//  A two-entry token queue and a two-entry output queue let input and
//  output stall independently; a full output queue pauses window reads.
// ----------------------------------------------------------------------------
module lzss_window_copy_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  lzwcd_tok_if.sink                   in_tok,
  lzwcd_byte_if.source                out_bytes,
  input  logic                        cfg_we,
  input  logic [lzwcd_pkg::CNT_W-1:0] cfg_wdata
);

  logic            tq_valid, tq_pop;
  lzwcd_pkg::tok_t tq_tok;

  // Accept and classify items
  lzwcd_front_q u_front_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tok   (in_tok),
    .tq_pop   (tq_pop),
    .tq_valid (tq_valid),
    .tq_tok   (tq_tok)
  );

  // Expand tokens through the window
  lzwcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tq_valid  (tq_valid),
    .tq_tok    (tq_tok),
    .tq_pop    (tq_pop),
    .out_bytes (out_bytes)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZSS window copy decoder. Tokens go in over the
// valid/ready token channel. A predictor keeps its own ring window, write
// position, byte count and output limit, and queues the bytes that each
// accepted token should produce. Each byte taken from the output channel is
// compared with the oldest queued byte. Directed tests cover the reset
// window, overlapping and saturated runs, and the output limit. Random
// traffic follows under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = lzwcd_pkg::CNT_W;
  localparam int SW = lzwcd_pkg::SYM_W;
  localparam int DW = lzwcd_pkg::DIST_W;
  localparam int BW = lzwcd_pkg::BYTE_W;
  localparam int AW = lzwcd_pkg::WIN_AW;

  localparam logic [CW-1:0] LIMIT_MAX = {CW{1'b1}};
  // longest run plus the two queued tokens, with margin
  localparam int SETTLE_CYCLES = 3 * (lzwcd_pkg::MAX_RUN + 1) + 20;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  logic [CW-1:0]  cfg_wdata;

  lzwcd_tok_if  tok_ch ();
  lzwcd_byte_if byte_ch ();

  lzss_window_copy_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tok    (tok_ch),
    .out_bytes (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic [BW-1:0]        win_mem [lzwcd_pkg::WINDOW_SIZE];
  logic [AW-1:0]        wr_pos;
  logic [CW-1:0]        byte_cnt;
  logic [CW-1:0]        out_limit;
  lzwcd_pkg::out_item_t pending_bytes [$];

  // Pacing and bookkeeping
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned err_cnt;
  int unsigned tokens_sent;
  int unsigned tokens_ignored;
  int unsigned bytes_checked;
  int unsigned limit_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Timeout: %0d bytes still expected", pending_bytes.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Queue one predicted byte and advance the byte count
  function automatic void emit_byte(input logic [BW-1:0] b_val, input logic last);
    lzwcd_pkg::out_item_t item;
    byte_cnt        = byte_cnt + 1'b1;
    item.out_byte   = b_val;
    item.block_done = (byte_cnt == out_limit);
    item.run_last   = last | item.block_done;
    pending_bytes.push_back(item);
  endfunction

  // Store one byte in the window and advance the write position
  function automatic void store_byte(input logic [BW-1:0] b_val);
    win_mem[wr_pos] = b_val;
    wr_pos          = wr_pos + 1'b1;
  endfunction

  // Expand one token into the bytes it should produce
  function automatic void expand_token(input logic [SW-1:0] sym,
                                       input logic [DW-1:0] dist_val);
    int unsigned   run_len;
    logic [AW-1:0] src;
    logic [BW-1:0] b_val;
    if (byte_cnt >= out_limit) begin
      tokens_ignored++;
      return;
    end
    if (sym < lzwcd_pkg::LITERAL_LIMIT) begin
      b_val = sym[BW-1:0];
      store_byte(b_val);
      emit_byte(b_val, 1'b1);
      return;
    end
    run_len = sym - lzwcd_pkg::SYMBOL_BASE + lzwcd_pkg::MIN_MATCH_BIAS;
    if (run_len > lzwcd_pkg::MAX_RUN) run_len = lzwcd_pkg::MAX_RUN;
    src = wr_pos - dist_val - 1'b1;
    for (int unsigned n = 0; n < run_len; n++) begin
      // stop copying once the limit is hit; cut bytes never reach the window
      if (byte_cnt >= out_limit) break;
      b_val = win_mem[src];
      store_byte(b_val);
      emit_byte(b_val, (n + 1) == run_len);
      src = src + 1'b1;
    end
  endfunction

  // Compare one received byte with the oldest expectation
  function automatic void check_byte(input lzwcd_pkg::out_item_t got);
    lzwcd_pkg::out_item_t want;
    if (pending_bytes.size() == 0) begin
      $error("unexpected byte: out_byte %02h run_last %0b block_done %0b",
             got.out_byte, got.run_last, got.block_done);
      err_cnt++;
      return;
    end
    want = pending_bytes.pop_front();
    bytes_checked++;
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
      err_cnt++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
      err_cnt++;
    end
    if (got.block_done !== want.block_done) begin
      $error("block_done: expected %0b, got %0b", want.block_done, got.block_done);
      err_cnt++;
    end
  endfunction

  // Take bytes from the output channel and stall it at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready)
        check_byte('{out_byte: byte_ch.out_byte, run_last: byte_ch.run_last,
                     block_done: byte_ch.block_done});
      byte_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Offer one token and hold it until the block takes it
  task automatic send_token(input logic [SW-1:0] sym, input logic [DW-1:0] dist_val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tok_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tok_ch.valid    <= 1'b1;
    tok_ch.symbol   <= sym;
    tok_ch.distance <= dist_val;
    do @(posedge clk); while (!tok_ch.ready);
    expand_token(sym, dist_val);
    tokens_sent++;
  endtask

  // Drop valid, wait for every expected byte, then let queued tokens settle
  task automatic wait_drain();
    tok_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the output limit while the block is idle
  task automatic set_limit(input logic [CW-1:0] limit);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    out_limit = limit;
    byte_cnt  = '0;
    limit_writes++;
    cfg_we <= 1'b0;
  endtask

  task automatic set_pace(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Copy from the untouched window and send literals at the byte extremes
  task automatic test_reset_window();
    set_limit(LIMIT_MAX);
    send_token(9'd256, 12'd0);
    send_token(9'd300, 12'd4095);
    send_token(9'h000, 12'hFFF);
    send_token(9'h0FF, 12'h000);
    send_token(9'h0A5, 12'hAAA);
    send_token(9'h05A, 12'h555);
  endtask

  // Overlapping runs, saturated run lengths and the widest distance
  task automatic test_overlap_runs();
    send_token(9'd313, 12'd0);
    send_token(9'd313, 12'd3);
    send_token(9'd314, 12'd1);
    send_token(9'd511, 12'd4095);
    send_token(9'd280, 12'd2048);
  endtask

  // No output at all with a zero limit
  task automatic test_zero_limit();
    set_limit('0);
    send_token(9'h041, 12'd0);
    send_token(9'd313, 12'd5);
    send_token(9'd260, 12'd4095);
  endtask

  // Cut runs at the limit and ignore tokens past it
  task automatic test_limit_cut();
    set_limit(24'd5);
    send_token(9'h031, 12'd0);
    send_token(9'h032, 12'd0);
    send_token(9'd313, 12'd1);
    send_token(9'h033, 12'd0);
    set_limit(24'd1);
    send_token(9'd280, 12'd0);
    send_token(9'h034, 12'd0);
  endtask

  // Random tokens: mostly runs and literals, a few saturated runs
  task automatic send_random_token();
    int unsigned   pick;
    logic [SW-1:0] sym;
    logic [DW-1:0] dist_val;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) dist_val = DW'($urandom);
    else dist_val = DW'($urandom_range(0, 31));
    if (pick < 35)      sym = SW'($urandom_range(0, 255));
    else if (pick < 70) sym = SW'($urandom_range(256, 270));
    else if (pick < 94) sym = SW'($urandom_range(271, 313));
    else                sym = SW'($urandom_range(314, 511));
    send_token(sym, dist_val);
  endtask

  // Send tokens until the count is reached or the limit cuts output off
  task automatic test_random_traffic(input int unsigned n_tokens,
                                     input logic [CW-1:0] limit);
    int unsigned made;
    made = 0;
    set_limit(limit);
    while (made < n_tokens && byte_cnt < out_limit) begin
      send_random_token();
      made++;
    end
    // a couple of tokens past the limit should vanish
    if (byte_cnt >= out_limit) repeat (2) send_random_token();
  endtask

  task automatic test_random_limits(input int unsigned n_blocks);
    repeat (n_blocks) test_random_traffic(40, CW'($urandom_range(20, 400)));
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    tok_ch.valid    = 1'b0;
    tok_ch.symbol   = '0;
    tok_ch.distance = '0;
    byte_ch.ready   = 1'b0;
    err_cnt         = 0;
    tokens_sent     = 0;
    tokens_ignored  = 0;
    bytes_checked   = 0;
    limit_writes    = 0;
    set_pace(6, 59);

    // Reset the predictor alongside the block
    foreach (win_mem[i]) win_mem[i] = lzwcd_pkg::SPACE_BYTE;
    wr_pos    = lzwcd_pkg::WP_RESET[AW-1:0];
    byte_cnt  = '0;
    out_limit = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_overlap_runs();
    test_zero_limit();
    test_limit_cut();

    test_random_traffic(80, LIMIT_MAX);
    test_random_limits(4);
    set_pace(59, 6);
    test_random_traffic(80, LIMIT_MAX);
    test_random_limits(4);
    set_pace(0, 0);
    test_random_traffic(40, LIMIT_MAX);
    test_random_limits(2);

    wait_drain();
    $display("Covered %0d tokens (%0d dropped past the limit), %0d bytes checked,",
             tokens_sent, tokens_ignored, bytes_checked);
    $display("%0d output limit settings including zero, one and the maximum",
             limit_writes);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== lzss_window_copy_decoder.f =====
design/lzwcd_pkg.sv
design/lzwcd_ifs.sv
design/lzwcd_ram.sv
design/lzwcd_front.sv
design/lzwcd_tok_fifo.sv
design/lzwcd_back.sv
design/lzwcd_front_q.sv
design/lzss_window_copy_decoder.sv
verif/tb_top.sv
